FILE: hw/rtl/ipp_pkg.sv
package ipp_pkg;

  localparam int POS_W = 24;
  localparam int TFRAC = 16;
  localparam int VEL_W = 20;
  localparam int SPD_W = 20;

  localparam int D_W     = POS_W + 1;
  localparam int A_MAG_W = (VEL_W > SPD_W) ? 2 * VEL_W : 2 * SPD_W;
  localparam int B_MAG_W = D_W + VEL_W + 1;
  localparam int C_W     = 2 * D_W;
  localparam int B2_W    = 2 * B_MAG_W;
  localparam int AC_W    = A_MAG_W + C_W + 2;
  localparam int DISC_W  = ((B2_W > AC_W) ? B2_W : AC_W) + 1;
  localparam int R_W     = (DISC_W + 1) / 2;
  localparam int NB_W    = ((B_MAG_W > R_W) ? B_MAG_W : R_W) + 1;
  localparam int NUM_W   = (C_W > NB_W) ? C_W : NB_W;
  localparam int DEN_W   = (B_MAG_W > A_MAG_W + 1) ? B_MAG_W : A_MAG_W + 1;
  localparam int DVD_W   = NUM_W + TFRAC;
  localparam int MAG_W   = POS_W + TFRAC + 1;
  localparam int TI_W    = MAG_W - TFRAC;
  localparam int PI_W    = VEL_W + TI_W;
  localparam int PF_W    = VEL_W + TFRAC;
  localparam int PM_W    = PI_W + 1;

  // operand split points for the wide products
  localparam int BL  = B_MAG_W / 2;
  localparam int BHW = B_MAG_W - BL;
  localparam int AL  = A_MAG_W / 2;
  localparam int AHW = A_MAG_W - AL;
  localparam int CL  = C_W / 2;
  localparam int CHW = C_W - CL;

  localparam logic [MAG_W-1:0] T_MAX = MAG_W'(1) << (POS_W + TFRAC);
  localparam longint POS_LO = -(longint'(1) << (POS_W - 1));
  localparam longint POS_HI = (longint'(1) << (POS_W - 1)) - 1;

  typedef enum logic [1:0] {
    STAT_HIT       = 2'd0,
    STAT_NO_ROOT   = 2'd1,
    STAT_NO_TARGET = 2'd2,
    STAT_NO_TIME   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_HOLD,
    KIND_SINGLE,
    KIND_PAIR
  } kind_e;

  typedef struct packed {
    logic                        present;
    logic [2:0][POS_W-1:0]       pos;
    logic [2:0][VEL_W-1:0]       vel;
  } tgt_t;

  typedef struct packed {
    tgt_t                 tgt;
    logic                 a_zero;
    logic                 a_neg;
    logic [A_MAG_W-1:0]   a_mag;
    logic                 b_zero;
    logic                 b_neg;
    logic [B_MAG_W-1:0]   b_mag;
    logic [C_W-1:0]       c;
    logic                 no_root;
    logic                 disc_zero;
  } sq_side_t;

  typedef struct packed {
    tgt_t        tgt;
    kind_e       kind;
    logic [1:0]  num_neg;
    logic        den_neg;
  } div_side_t;

endpackage

FILE: hw/rtl/ipp_front.sv
module ipp_front import ipp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     vld_i,
  input  tgt_t                     tgt_i,
  input  logic [2:0][POS_W-1:0]    shooter_i,
  input  logic [SPD_W-1:0]         speed_i,
  output logic                     vld_o,
  output logic [DISC_W-1:0]        disc_o,
  output sq_side_t                 side_o
);

  logic [6:0] vld_q;

  // stage 1
  tgt_t                    t1_q;
  logic signed [D_W-1:0]   d1_q [3];
  logic [SPD_W-1:0]        s1_q;
  // stage 2
  tgt_t                          t2_q;
  logic signed [2*VEL_W-1:0]     vv2_q [3];
  logic signed [D_W+VEL_W-1:0]   dv2_q [3];
  logic signed [2*D_W-1:0]       dd2_q [3];
  logic [2*SPD_W-1:0]            ss2_q;
  // stage 3
  tgt_t                      t3_q;
  logic signed [A_MAG_W:0]   a3_q, a3_d;
  logic signed [B_MAG_W:0]   b3_q, b3_d;
  logic [C_W-1:0]            c3_q, c3_d;
  // stages 4 to 7
  sq_side_t side4_q, side4_d, side5_q, side6_q, side7_q, side7_d;
  logic [2*BHW-1:0]      bhh5_q;
  logic [BHW+BL-1:0]     bhl5_q;
  logic [2*BL-1:0]       bll5_q;
  logic [AHW+CHW-1:0]    ahch5_q;
  logic [AHW+CL-1:0]     ahcl5_q;
  logic [AL+CHW-1:0]     alch5_q;
  logic [AL+CL-1:0]      alcl5_q;
  logic [B2_W-1:0]       b2_6_q;
  logic [AC_W-1:0]       ac6_q;
  logic [DISC_W-1:0]     disc7_q, disc7_d;

  logic [A_MAG_W-1:0]          vsum;
  logic signed [B_MAG_W-1:0]   dsum;
  logic [DISC_W:0]             diff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[5:0], vld_i};
    end
  end

  always_comb begin
    vsum = A_MAG_W'(vv2_q[0][2*VEL_W-2:0]) + A_MAG_W'(vv2_q[1][2*VEL_W-2:0])
         + A_MAG_W'(vv2_q[2][2*VEL_W-2:0]);
    a3_d = $signed({1'b0, vsum}) - $signed({1'b0, A_MAG_W'(ss2_q)});
    dsum = B_MAG_W'(dv2_q[0]) + B_MAG_W'(dv2_q[1]) + B_MAG_W'(dv2_q[2]);
    b3_d = {dsum, 1'b0};
    c3_d = C_W'(dd2_q[0][2*D_W-2:0]) + C_W'(dd2_q[1][2*D_W-2:0])
         + C_W'(dd2_q[2][2*D_W-2:0]);
  end

  always_comb begin
    side4_d           = '0;
    side4_d.tgt       = t3_q;
    side4_d.a_neg     = a3_q[A_MAG_W];
    side4_d.a_mag     = a3_q[A_MAG_W] ? A_MAG_W'(-a3_q) : A_MAG_W'(a3_q);
    side4_d.a_zero    = (a3_q == '0);
    side4_d.b_neg     = b3_q[B_MAG_W];
    side4_d.b_mag     = b3_q[B_MAG_W] ? B_MAG_W'(-b3_q) : B_MAG_W'(b3_q);
    side4_d.b_zero    = (b3_q == '0);
    side4_d.c         = c3_q;
  end

  always_comb begin
    side7_d = side6_q;
    diff    = {1'b0, DISC_W'(b2_6_q)} - {1'b0, DISC_W'(ac6_q)};
    if (side6_q.a_neg) begin
      disc7_d         = DISC_W'(b2_6_q) + DISC_W'(ac6_q);
      side7_d.no_root = 1'b0;
    end else begin
      disc7_d         = diff[DISC_W-1:0];
      side7_d.no_root = diff[DISC_W];
    end
    side7_d.disc_zero = (disc7_d == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q <= tgt_i;
      s1_q <= speed_i;
      for (int k = 0; k < 3; k++) begin
        d1_q[k] <= D_W'($signed(tgt_i.pos[k])) - D_W'($signed(shooter_i[k]));
      end

      t2_q  <= t1_q;
      ss2_q <= (2*SPD_W)'(s1_q) * (2*SPD_W)'(s1_q);
      for (int k = 0; k < 3; k++) begin
        vv2_q[k] <= (2*VEL_W)'($signed(t1_q.vel[k])) * (2*VEL_W)'($signed(t1_q.vel[k]));
        dv2_q[k] <= (D_W+VEL_W)'(d1_q[k]) * (D_W+VEL_W)'($signed(t1_q.vel[k]));
        dd2_q[k] <= (2*D_W)'(d1_q[k]) * (2*D_W)'(d1_q[k]);
      end

      t3_q <= t2_q;
      a3_q <= a3_d;
      b3_q <= b3_d;
      c3_q <= c3_d;

      side4_q <= side4_d;

      side5_q <= side4_q;
      bhh5_q  <= (2*BHW)'(side4_q.b_mag[B_MAG_W-1:BL]) * (2*BHW)'(side4_q.b_mag[B_MAG_W-1:BL]);
      bhl5_q  <= (BHW+BL)'(side4_q.b_mag[B_MAG_W-1:BL]) * (BHW+BL)'(side4_q.b_mag[BL-1:0]);
      bll5_q  <= (2*BL)'(side4_q.b_mag[BL-1:0]) * (2*BL)'(side4_q.b_mag[BL-1:0]);
      ahch5_q <= (AHW+CHW)'(side4_q.a_mag[A_MAG_W-1:AL]) * (AHW+CHW)'(side4_q.c[C_W-1:CL]);
      ahcl5_q <= (AHW+CL)'(side4_q.a_mag[A_MAG_W-1:AL]) * (AHW+CL)'(side4_q.c[CL-1:0]);
      alch5_q <= (AL+CHW)'(side4_q.a_mag[AL-1:0]) * (AL+CHW)'(side4_q.c[C_W-1:CL]);
      alcl5_q <= (AL+CL)'(side4_q.a_mag[AL-1:0]) * (AL+CL)'(side4_q.c[CL-1:0]);

      side6_q <= side5_q;
      b2_6_q  <= (B2_W'(bhh5_q) << (2*BL)) + (B2_W'(bhl5_q) << (BL+1)) + B2_W'(bll5_q);
      ac6_q   <= ((AC_W'(ahch5_q) << (AL+CL)) + (AC_W'(ahcl5_q) << AL)
                + (AC_W'(alch5_q) << CL) + AC_W'(alcl5_q)) << 2;

      side7_q <= side7_d;
      disc7_q <= disc7_d;
    end
  end

  assign vld_o  = vld_q[6];
  assign disc_o = disc7_q;
  assign side_o = side7_q;

endmodule

FILE: hw/rtl/ipp_sqrt.sv
module ipp_sqrt import ipp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  logic [DISC_W-1:0]   disc_i,
  input  sq_side_t            side_i,
  output logic                vld_o,
  output logic [R_W-1:0]      root_o,
  output sq_side_t            side_o
);

  logic                vld_q  [R_W];
  logic [R_W+1:0]      rem_q  [R_W];
  logic [R_W-1:0]      root_q [R_W];
  logic [2*R_W-1:0]    val_q  [R_W];
  sq_side_t            side_q [R_W];

  // one root bit per stage, two radicand bits consumed per stage
  for (genvar g = 0; g < R_W; g++) begin : g_stage
    logic              vld_in;
    logic [R_W+1:0]    rem_in;
    logic [R_W-1:0]    root_in;
    logic [2*R_W-1:0]  val_in;
    sq_side_t          side_in;
    logic [R_W+3:0]    cur, trial, rem_nx;
    logic              take;

    if (g == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign val_in  = (2*R_W)'(disc_i);
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign val_in  = val_q[g-1];
      assign side_in = side_q[g-1];
    end

    always_comb begin
      cur    = {rem_in, val_in[2*R_W-1 -: 2]};
      trial  = (R_W+4)'({root_in, 2'b01});
      take   = (cur >= trial);
      rem_nx = take ? cur - trial : cur;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= rem_nx[R_W+1:0];
        root_q[g] <= {root_in[R_W-2:0], take};
        val_q[g]  <= val_in << 2;
        side_q[g] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[R_W-1];
  assign root_o = root_q[R_W-1];
  assign side_o = side_q[R_W-1];

endmodule

FILE: hw/rtl/ipp_div.sv
module ipp_div import ipp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   vld_i,
  input  logic [R_W-1:0]         root_i,
  input  sq_side_t               side_i,
  output logic                   vld_o,
  output logic [MAG_W-1:0]       q_o   [2],
  output logic                   big_o [2],
  output div_side_t              side_o
);

  // operand setup
  logic signed [NUM_W:0]   b_s, r_s, n1, n2;
  logic [NUM_W-1:0]        num_d [2];
  logic [DEN_W-1:0]        den_d;
  div_side_t               pside_d;

  logic                    p_vld_q;
  logic [NUM_W-1:0]        p_num_q [2];
  logic [DEN_W-1:0]        p_den_q;
  div_side_t               p_side_q;

  always_comb begin
    b_s = side_i.b_neg ? -$signed({1'b0, NUM_W'(side_i.b_mag)})
                       :  $signed({1'b0, NUM_W'(side_i.b_mag)});
    r_s = $signed({1'b0, NUM_W'(root_i)});
    n1  = r_s - b_s;
    n2  = -r_s - b_s;

    num_d[0]         = n1[NUM_W] ? NUM_W'(-n1) : NUM_W'(n1);
    num_d[1]         = n2[NUM_W] ? NUM_W'(-n2) : NUM_W'(n2);
    den_d            = DEN_W'({side_i.a_mag, 1'b0});
    pside_d.tgt      = side_i.tgt;
    pside_d.kind     = KIND_PAIR;
    pside_d.num_neg  = {n2[NUM_W], n1[NUM_W]};
    pside_d.den_neg  = side_i.a_neg;

    if (!side_i.tgt.present) begin
      pside_d.kind = KIND_NONE;
    end else if (side_i.a_zero) begin
      if (side_i.b_zero) begin
        pside_d.kind = KIND_HOLD;
      end else begin
        // linear case: t = -c / b
        pside_d.kind       = KIND_SINGLE;
        num_d[0]           = NUM_W'(side_i.c);
        pside_d.num_neg[0] = 1'b1;
        den_d              = DEN_W'(side_i.b_mag);
        pside_d.den_neg    = side_i.b_neg;
      end
    end else if (side_i.no_root) begin
      pside_d.kind = KIND_HOLD;
    end else if (side_i.disc_zero) begin
      pside_d.kind       = KIND_SINGLE;
      num_d[0]           = NUM_W'(side_i.b_mag);
      pside_d.num_neg[0] = !side_i.b_neg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (en_i) begin
      p_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_num_q  <= num_d;
      p_den_q  <= den_d;
      p_side_q <= pside_d;
    end
  end

  // restoring divider, one quotient bit per stage, two lanes sharing the divisor
  logic               vld_q  [DVD_W];
  logic [DEN_W-1:0]   den_q  [DVD_W];
  div_side_t          side_q [DVD_W];
  logic [DEN_W-1:0]   rem_q  [DVD_W][2];
  logic [DVD_W-1:0]   dvd_q  [DVD_W][2];
  logic [MAG_W-1:0]   q_q    [DVD_W][2];
  logic               big_q  [DVD_W][2];

  for (genvar g = 0; g < DVD_W; g++) begin : g_stage
    logic              vld_in;
    logic [DEN_W-1:0]  den_in;
    div_side_t         side_in;

    if (g == 0) begin : g_first
      assign vld_in  = p_vld_q;
      assign den_in  = p_den_q;
      assign side_in = p_side_q;
    end else begin : g_next
      assign vld_in  = vld_q[g-1];
      assign den_in  = den_q[g-1];
      assign side_in = side_q[g-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[g]  <= den_in;
        side_q[g] <= side_in;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DEN_W-1:0]  rem_in;
      logic [DVD_W-1:0]  dvd_in;
      logic [MAG_W-1:0]  q_in;
      logic              big_in;
      logic [DEN_W:0]    cur, rem_nx;
      logic              take;

      if (g == 0) begin : g_first
        assign rem_in = '0;
        assign dvd_in = {p_num_q[l], {TFRAC{1'b0}}};
        assign q_in   = '0;
        assign big_in = 1'b0;
      end else begin : g_next
        assign rem_in = rem_q[g-1][l];
        assign dvd_in = dvd_q[g-1][l];
        assign q_in   = q_q[g-1][l];
        assign big_in = big_q[g-1][l];
      end

      always_comb begin
        cur    = {rem_in, dvd_in[DVD_W-1]};
        take   = (cur >= {1'b0, den_in});
        rem_nx = take ? cur - {1'b0, den_in} : cur;
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[g][l] <= rem_nx[DEN_W-1:0];
          dvd_q[g][l] <= dvd_in << 1;
          q_q[g][l]   <= {q_in[MAG_W-2:0], take};
          // any quotient bit pushed out the top means the time limit is exceeded
          big_q[g][l] <= big_in | q_in[MAG_W-1];
        end
      end
    end
  end

  assign vld_o    = vld_q[DVD_W-1];
  assign side_o   = side_q[DVD_W-1];
  assign q_o[0]   = q_q[DVD_W-1][0];
  assign q_o[1]   = q_q[DVD_W-1][1];
  assign big_o[0] = big_q[DVD_W-1][0];
  assign big_o[1] = big_q[DVD_W-1][1];

endmodule

FILE: hw/rtl/ipp_back.sv
module ipp_back import ipp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  vld_i,
  input  logic [MAG_W-1:0]      q_i   [2],
  input  logic                  big_i [2],
  input  div_side_t             side_i,
  output logic                  vld_o,
  output logic [2:0][POS_W-1:0] pred_o,
  output status_e               status_o
);

  logic [3:0] vld_q;

  // stage 1: clamp and sign of each root time
  logic [MAG_W-1:0]  m1_q [2];
  logic              n1_q [2];
  div_side_t         side1_q;
  // stage 2: pick the time
  logic              found2_q, neg2_q, found2_d, neg2_d;
  logic [MAG_W-1:0]  mag2_q, mag2_d;
  status_e           stat2_q, stat2_d;
  tgt_t              t2_q;
  // stage 3: scale velocity by time
  logic [PI_W-1:0]   pi3_q [3];
  logic [PF_W-1:0]   pf3_q [3];
  logic              sub3_q [3];
  logic              found3_q;
  status_e           stat3_q;
  tgt_t              t3_q;
  // stage 4: output register
  logic [2:0][POS_W-1:0] pred4_q;
  status_e               stat4_q;

  logic              ok0, ok1;
  logic [VEL_W-1:0]  av [3];
  logic [POS_W-1:0]  pos4_d [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  always_comb begin
    ok0      = !n1_q[0] && (m1_q[0] != '0);
    ok1      = !n1_q[1] && (m1_q[1] != '0);
    found2_d = 1'b0;
    neg2_d   = 1'b0;
    mag2_d   = m1_q[0];
    stat2_d  = STAT_HIT;
    case (side1_q.kind)
      KIND_NONE: begin
        stat2_d = STAT_NO_TARGET;
      end
      KIND_HOLD: begin
        stat2_d = STAT_NO_ROOT;
      end
      KIND_SINGLE: begin
        found2_d = 1'b1;
        neg2_d   = n1_q[0];
      end
      KIND_PAIR: begin
        // keep the earliest positive root
        if (ok0 && ok1) begin
          found2_d = 1'b1;
          mag2_d   = (m1_q[0] < m1_q[1]) ? m1_q[0] : m1_q[1];
        end else if (ok0) begin
          found2_d = 1'b1;
        end else if (ok1) begin
          found2_d = 1'b1;
          mag2_d   = m1_q[1];
        end else begin
          stat2_d = STAT_NO_TIME;
        end
      end
      default: begin
        stat2_d = STAT_NO_TARGET;
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      av[k] = t2_q.vel[k][VEL_W-1] ? VEL_W'(-$signed(t2_q.vel[k]))
                                   : VEL_W'(t2_q.vel[k]);
    end
  end

  always_comb begin
    logic [PM_W-1:0]        pm;
    logic signed [PM_W:0]   r;
    for (int k = 0; k < 3; k++) begin
      pm = PM_W'(pi3_q[k]) + PM_W'(pf3_q[k] >> TFRAC);
      r  = sub3_q[k] ? (PM_W+1)'($signed(t3_q.pos[k])) - $signed({1'b0, pm})
                     : (PM_W+1)'($signed(t3_q.pos[k])) + $signed({1'b0, pm});
      if (!found3_q) begin
        pos4_d[k] = (stat3_q == STAT_NO_TARGET) ? '0 : t3_q.pos[k];
      end else if (r < (PM_W+1)'(POS_LO)) begin
        pos4_d[k] = POS_W'(POS_LO);
      end else if (r > (PM_W+1)'(POS_HI)) begin
        pos4_d[k] = POS_W'(POS_HI);
      end else begin
        pos4_d[k] = r[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q <= side_i;
      for (int l = 0; l < 2; l++) begin
        m1_q[l] <= (big_i[l] || q_i[l] > T_MAX) ? T_MAX : q_i[l];
        n1_q[l] <= (side_i.num_neg[l] != side_i.den_neg) && (big_i[l] || q_i[l] != '0);
      end

      found2_q <= found2_d;
      neg2_q   <= neg2_d;
      mag2_q   <= mag2_d;
      stat2_q  <= stat2_d;
      t2_q     <= side1_q.tgt;

      found3_q <= found2_q;
      stat3_q  <= stat2_q;
      t3_q     <= t2_q;
      for (int k = 0; k < 3; k++) begin
        pi3_q[k]  <= PI_W'(av[k]) * PI_W'(mag2_q[MAG_W-1:TFRAC]);
        pf3_q[k]  <= PF_W'(av[k]) * PF_W'(mag2_q[TFRAC-1:0]);
        sub3_q[k] <= t2_q.vel[k][VEL_W-1] ^ neg2_q;
      end

      stat4_q <= stat3_q;
      for (int k = 0; k < 3; k++) begin
        pred4_q[k] <= pos4_d[k];
      end
    end
  end

  assign vld_o    = vld_q[3];
  assign pred_o   = pred4_q;
  assign status_o = stat4_q;

endmodule

FILE: hw/rtl/intercept_point_predictor_unit.sv
// Intercept point predictor: solves the constant-velocity intercept time and advances the target.
// The pipeline runs in order: setup, square root, divide, finish.
// Throughput: one item per cycle; the whole pipeline holds while a result waits under stall.
// Reset clears only the valid bits of the pipeline; data registers are not reset.
module intercept_point_predictor_unit import ipp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     target_present_i,
  input  logic signed [POS_W-1:0]  target_x_i,
  input  logic signed [POS_W-1:0]  target_y_i,
  input  logic signed [POS_W-1:0]  target_z_i,
  input  logic signed [VEL_W-1:0]  target_vel_x_i,
  input  logic signed [VEL_W-1:0]  target_vel_y_i,
  input  logic signed [VEL_W-1:0]  target_vel_z_i,
  input  logic signed [POS_W-1:0]  shooter_x_i,
  input  logic signed [POS_W-1:0]  shooter_y_i,
  input  logic signed [POS_W-1:0]  shooter_z_i,
  input  logic [SPD_W-1:0]         projectile_speed_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [POS_W-1:0]  predicted_x_o,
  output logic signed [POS_W-1:0]  predicted_y_o,
  output logic signed [POS_W-1:0]  predicted_z_o,
  output logic [1:0]               status_o
);

  logic                   en;
  tgt_t                   tgt;
  logic [2:0][POS_W-1:0]  shooter;

  logic                   f_vld;
  logic [DISC_W-1:0]      f_disc;
  sq_side_t               f_side;
  logic                   s_vld;
  logic [R_W-1:0]         s_root;
  sq_side_t               s_side;
  logic                   d_vld;
  logic [MAG_W-1:0]       d_q   [2];
  logic                   d_big [2];
  div_side_t              d_side;
  logic [2:0][POS_W-1:0]  pred;
  status_e                stat;

  // hold every stage while the output item is not taken
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  assign tgt.present = target_present_i;
  assign tgt.pos     = {target_z_i, target_y_i, target_x_i};
  assign tgt.vel     = {target_vel_z_i, target_vel_y_i, target_vel_x_i};
  assign shooter     = {shooter_z_i, shooter_y_i, shooter_x_i};

  ipp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .vld_i     (in_valid_i),
    .tgt_i     (tgt),
    .shooter_i (shooter),
    .speed_i   (projectile_speed_i),
    .vld_o     (f_vld),
    .disc_o    (f_disc),
    .side_o    (f_side)
  );

  ipp_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (f_vld),
    .disc_i (f_disc),
    .side_i (f_side),
    .vld_o  (s_vld),
    .root_o (s_root),
    .side_o (s_side)
  );

  ipp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_vld),
    .root_i (s_root),
    .side_i (s_side),
    .vld_o  (d_vld),
    .q_o    (d_q),
    .big_o  (d_big),
    .side_o (d_side)
  );

  ipp_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (d_vld),
    .q_i      (d_q),
    .big_i    (d_big),
    .side_i   (d_side),
    .vld_o    (out_valid_o),
    .pred_o   (pred),
    .status_o (stat)
  );

  assign predicted_x_o = pred[0];
  assign predicted_y_o = pred[1];
  assign predicted_z_o = pred[2];
  assign status_o      = stat;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top import ipp_pkg::*;;

  localparam logic [63:0] TIME_LIMIT = 64'd1 << (POS_W + TFRAC);
  localparam int          WDOG_LIMIT = 3000;
  localparam int          N_RANDOM   = 630;

  typedef struct {
    logic                    present;
    logic signed [POS_W-1:0] tx, ty, tz;
    logic signed [VEL_W-1:0] vx, vy, vz;
    logic signed [POS_W-1:0] sx, sy, sz;
    logic [SPD_W-1:0]        spd;
  } target_item_t;

  typedef struct {
    logic signed [POS_W-1:0] px, py, pz;
    status_e                 status;
  } aim_point_t;

  typedef struct {
    target_item_t item;
    bit           typed;
    aim_point_t   point;
  } directed_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic                    target_present_i = 1'b0;
  logic signed [POS_W-1:0] target_x_i = '0, target_y_i = '0, target_z_i = '0;
  logic signed [VEL_W-1:0] target_vel_x_i = '0, target_vel_y_i = '0, target_vel_z_i = '0;
  logic signed [POS_W-1:0] shooter_x_i = '0, shooter_y_i = '0, shooter_z_i = '0;
  logic [SPD_W-1:0]        projectile_speed_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b1;
  logic signed [POS_W-1:0] predicted_x_o, predicted_y_o, predicted_z_o;
  logic [1:0]              status_o;

  aim_point_t    pending_points[$];
  directed_row_t directed_rows[$];
  int            mismatches = 0;
  int            quiet_cycles = 0;
  int            rx_cycle = 0;

  intercept_point_predictor_unit dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] mag64(longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  function automatic logic [63:0] flight_time(logic [127:0] num, logic [63:0] den);
    logic [127:0] q;
    q = (num << TFRAC) / {64'd0, den};
    return (q > {64'd0, TIME_LIMIT}) ? TIME_LIMIT : q[63:0];
  endfunction

  function automatic logic [63:0] root_flight_time(longint num, longint den, output bit neg);
    logic [63:0] m;
    m = flight_time({64'd0, mag64(num)}, mag64(den));
    neg = ((num < 0) != (den < 0)) && m != 0;
    return m;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [127:0] v);
    logic [63:0] r, cand;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = r | (64'd1 << i);
      if ({64'd0, cand} * {64'd0, cand} <= v) r = cand;
    end
    return r;
  endfunction

  function automatic logic [POS_W-1:0] advance_axis(longint pos, longint vel, bit neg,
                                                    logic [63:0] tmag);
    logic [63:0] av, ti, tf, pm;
    longint r;
    av = mag64(vel);
    ti = tmag >> TFRAC;
    tf = tmag & ((64'd1 << TFRAC) - 1);
    pm = av * ti + ((av * tf) >> TFRAC);
    r = ((vel < 0) != neg) ? pos - longint'(pm) : pos + longint'(pm);
    if (r < POS_LO) r = POS_LO;
    if (r > POS_HI) r = POS_HI;
    return r[POS_W-1:0];
  endfunction

  function automatic aim_point_t predict_intercept(target_item_t it);
    aim_point_t pt;
    longint p[3], v[3], d[3];
    longint a, b, c, s, rt;
    logic [127:0] b2, ac, disc;
    logic [63:0] tmag, m1, m2;
    bit neg, found, n1, n2, ok1, ok2;
    status_e st;
    if (!it.present) begin
      pt.px = '0; pt.py = '0; pt.pz = '0; pt.status = STAT_NO_TARGET;
      return pt;
    end
    p[0] = it.tx; p[1] = it.ty; p[2] = it.tz;
    v[0] = it.vx; v[1] = it.vy; v[2] = it.vz;
    d[0] = p[0] - longint'(it.sx);
    d[1] = p[1] - longint'(it.sy);
    d[2] = p[2] - longint'(it.sz);
    s = longint'({44'd0, it.spd});
    a = v[0] * v[0] + v[1] * v[1] + v[2] * v[2] - s * s;
    b = 2 * (d[0] * v[0] + d[1] * v[1] + d[2] * v[2]);
    c = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
    st = STAT_HIT; neg = 0; found = 0; tmag = '0;
    if (a == 0) begin
      if (b == 0) begin
        st = STAT_NO_ROOT;
      end else begin
        tmag = flight_time({64'd0, 64'(c)}, mag64(b));
        neg = b > 0 && tmag != 0;
        found = 1;
      end
    end else begin
      b2 = {64'd0, mag64(b)} * {64'd0, mag64(b)};
      ac = ({64'd0, 64'(c)} * {64'd0, mag64(a)}) << 2;
      disc = b2;
      if (a < 0) disc = b2 + ac;
      else if (b2 < ac) st = STAT_NO_ROOT;
      else disc = b2 - ac;
      if (st == STAT_HIT) begin
        if (disc == 0) begin
          tmag = root_flight_time(-b, 2 * a, neg);
          found = 1;
        end else begin
          rt = longint'(floor_sqrt(disc));
          m1 = root_flight_time(-b + rt, 2 * a, n1);
          m2 = root_flight_time(-b - rt, 2 * a, n2);
          ok1 = !n1 && m1 != 0;
          ok2 = !n2 && m2 != 0;
          found = 1;
          if (ok1 && ok2) tmag = (m1 < m2) ? m1 : m2;
          else if (ok1) tmag = m1;
          else if (ok2) tmag = m2;
          else begin
            found = 0;
            st = STAT_NO_TIME;
          end
          neg = 0;
        end
      end
    end
    if (found) begin
      pt.px = advance_axis(p[0], v[0], neg, tmag);
      pt.py = advance_axis(p[1], v[1], neg, tmag);
      pt.pz = advance_axis(p[2], v[2], neg, tmag);
    end else begin
      pt.px = it.tx; pt.py = it.ty; pt.pz = it.tz;
    end
    pt.status = st;
    return pt;
  endfunction

  function automatic target_item_t make_item(bit pr, longint tx, longint ty, longint tz,
                                             longint vx, longint vy, longint vz,
                                             longint sx, longint sy, longint sz, longint spd);
    target_item_t it;
    it.present = pr;
    it.tx = tx[POS_W-1:0]; it.ty = ty[POS_W-1:0]; it.tz = tz[POS_W-1:0];
    it.vx = vx[VEL_W-1:0]; it.vy = vy[VEL_W-1:0]; it.vz = vz[VEL_W-1:0];
    it.sx = sx[POS_W-1:0]; it.sy = sy[POS_W-1:0]; it.sz = sz[POS_W-1:0];
    it.spd = spd[SPD_W-1:0];
    return it;
  endfunction

  function automatic void add_row(target_item_t it, bit typed, longint px, longint py,
                                  longint pz, status_e st);
    directed_row_t row;
    row.item = it;
    row.typed = typed;
    row.point.px = px[POS_W-1:0];
    row.point.py = py[POS_W-1:0];
    row.point.pz = pz[POS_W-1:0];
    row.point.status = st;
    directed_rows.push_back(row);
  endfunction

  function automatic longint rnd_signed(int w);
    logic [31:0] r;
    r = $urandom;
    return longint'($signed(r << (32 - w))) >>> (32 - w);
  endfunction

  function automatic target_item_t random_item();
    target_item_t it;
    int mode, k;
    mode = $urandom_range(0, 15);
    it = make_item(1, rnd_signed(POS_W), rnd_signed(POS_W), rnd_signed(POS_W),
                   rnd_signed(VEL_W), rnd_signed(VEL_W), rnd_signed(VEL_W),
                   rnd_signed(POS_W), rnd_signed(POS_W), rnd_signed(POS_W),
                   $urandom_range(0, (1 << SPD_W) - 1));
    if (mode == 0) begin
      it.present = 0;
    end else if (mode >= 4) begin
      // plausible engagement: nearby target, modest speeds
      it = make_item(1, $signed($urandom_range(0, 200000)) - 100000,
                     $signed($urandom_range(0, 200000)) - 100000,
                     $signed($urandom_range(0, 200000)) - 100000,
                     $signed($urandom_range(0, 4000)) - 2000,
                     $signed($urandom_range(0, 4000)) - 2000,
                     $signed($urandom_range(0, 4000)) - 2000,
                     $signed($urandom_range(0, 2000)) - 1000,
                     $signed($urandom_range(0, 2000)) - 1000,
                     $signed($urandom_range(0, 2000)) - 1000,
                     $urandom_range(0, 5000));
      if (mode >= 13) begin
        // projectile exactly as fast as the target: linear case
        k = $urandom_range(0, 600);
        it.vx = VEL_W'(3 * k * ($urandom_range(0, 1) ? 1 : -1));
        it.vy = VEL_W'(4 * k * ($urandom_range(0, 1) ? 1 : -1));
        it.vz = '0;
        it.spd = SPD_W'(5 * k);
      end
    end
    return it;
  endfunction

  task automatic send_item(target_item_t it, bit allow_idle);
    target_present_i <= it.present;
    target_x_i <= it.tx; target_y_i <= it.ty; target_z_i <= it.tz;
    target_vel_x_i <= it.vx; target_vel_y_i <= it.vy; target_vel_z_i <= it.vz;
    shooter_x_i <= it.sx; shooter_y_i <= it.sy; shooter_z_i <= it.sz;
    projectile_speed_i <= it.spd;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (allow_idle && $urandom_range(0, 99) < 25) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    aim_point_t exp_pt;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: %0d %0d %0d st=%0d",
                                       predicted_x_o, predicted_y_o, predicted_z_o, status_o);
      end else begin
        exp_pt = pending_points.pop_front();
        if (predicted_x_o !== exp_pt.px || predicted_y_o !== exp_pt.py ||
            predicted_z_o !== exp_pt.pz || status_o !== exp_pt.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d %0d %0d st=%0d got %0d %0d %0d st=%0d",
                     exp_pt.px, exp_pt.py, exp_pt.pz, exp_pt.status,
                     predicted_x_o, predicted_y_o, predicted_z_o, status_o);
        end
      end
    end
  end

  // receiver stall: one long hold-off, one clean stretch, random otherwise
  always @(posedge clk_i) begin
    if (rst_ni) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle >= 300 && rx_cycle < 700) out_stall_i <= 1'b1;
      else if (rx_cycle >= 900 && rx_cycle < 1300) out_stall_i <= 1'b0;
      else out_stall_i <= ($urandom_range(0, 99) < 25);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    target_item_t it;
    add_row(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0, STAT_NO_TARGET);
    add_row(make_item(0, POS_HI, POS_LO, POS_HI, 524287, -524288, 1, 5, 6, 7, 1048575),
            1, 0, 0, 0, STAT_NO_TARGET);
    // still target, zero projectile speed
    add_row(make_item(1, 1000, -2000, 3000, 0, 0, 0, 0, 0, 0, 0),
            1, 1000, -2000, 3000, STAT_NO_ROOT);
    // target sitting on the shooter
    add_row(make_item(1, 77, 88, 99, 0, 0, 0, 77, 88, 99, 500), 1, 77, 88, 99, STAT_HIT);
    add_row(make_item(1, 1000, 0, 0, 3, 4, 0, 0, 0, 0, 5), 0, 0, 0, 0, STAT_HIT);
    add_row(make_item(1, -1000, 0, 0, 3, 4, 0, 0, 0, 0, 5), 0, 0, 0, 0, STAT_HIT);
    add_row(make_item(1, 0, 1000, 0, 100, 0, 0, 0, 0, 0, 10), 1, 0, 1000, 0, STAT_NO_ROOT);
    add_row(make_item(1, 1000, 0, 0, 100, 0, 0, 0, 0, 0, 10), 1, 1000, 0, 0, STAT_NO_TIME);
    add_row(make_item(1, -100, 0, 0, 2, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, STAT_HIT);
    add_row(make_item(1, 100, 0, 0, 2, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, STAT_HIT);
    add_row(make_item(1, 5000, -3000, 700, 40, -25, 9, -100, 50, 0, 300), 0, 0, 0, 0, STAT_HIT);
    add_row(make_item(1, POS_HI, POS_HI, POS_HI, 524287, 524287, 524287,
                      POS_LO, POS_LO, POS_LO, 1048575), 0, 0, 0, 0, STAT_HIT);
    add_row(make_item(1, POS_LO, POS_LO, POS_LO, -524288, -524288, -524288,
                      POS_HI, POS_HI, POS_HI, 1), 0, 0, 0, 0, STAT_HIT);
    add_row(make_item(1, POS_HI, POS_LO, 0, 524287, -524288, 0, POS_LO, POS_HI, 0, 0),
            0, 0, 0, 0, STAT_HIT);
    add_row(make_item(1, POS_LO, 0, 0, 1, 0, 0, POS_HI, 0, 0, 1), 0, 0, 0, 0, STAT_HIT);
    // linear case with a huge flight time: saturate
    add_row(make_item(1, POS_HI, 0, 0, 3, 4, 0, POS_LO, 0, 0, 5), 0, 0, 0, 0, STAT_HIT);
    add_row(make_item(1, 0, 0, 1, 524287, 0, 0, 0, 0, 0, 524287), 0, 0, 0, 0, STAT_HIT);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      pending_points.push_back(directed_rows[i].typed ? directed_rows[i].point
                                                      : predict_intercept(directed_rows[i].item));
      send_item(directed_rows[i].item, 1);
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      it = random_item();
      pending_points.push_back(predict_intercept(it));
      // no sender gaps over a middle stretch
      send_item(it, !(n >= 250 && n < 400));
    end
    in_valid_i <= 1'b0;

    wait (pending_points.size() == 0);
    repeat (150) @(posedge clk_i);
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
